[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/tmcw_pkg.sv]
// ----------------------------------------------------------------------------
// tmcw_pkg
// shared constants and the command and status types of the console writer
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = ROWS * COLS;
  localparam int ADDR_W   = $clog2(CELLS);

  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int POS_W       = 11;
  localparam int CELL_ADDR_W = 11;
  localparam int CELL_W      = 16;
  localparam int COL_SUM_W   = COL_W + 2;

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] RESET_ATTR = 8'h09;

  typedef struct packed {
    logic capture;
    logic step;
    logic clear_cursor;
    logic cnt_clr;
    logic cnt_inc;
    logic fill_en;
    logic init_fill;
    logic copy_en;
    logic read_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       scroll_req;
    logic       copy_end;
    logic       fill_end;
    logic [1:0] kind;
  } status_t;

endpackage

[hw/rtl/tmcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tmcw_ctrl
// sequencer: reset fill, item execution, scroll and clear sweeps, result hand-off
// ----------------------------------------------------------------------------
module tmcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tmcw_pkg::status_t status,
  output tmcw_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_busy;

  assign in_stall = (state != ST_IDLE);
  assign out_busy = out_valid && out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_en   = 1'b1;
        cmd.init_fill = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (status.fill_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.kind)
          tmcw_pkg::KIND_PUT, tmcw_pkg::KIND_REMOVE: begin
            cmd.step = 1'b1;
            if (status.scroll_req) begin
              cmd.cnt_clr = 1'b1;
              state_next  = ST_SCROLL;
            end else begin
              state_next = ST_DONE;
            end
          end
          tmcw_pkg::KIND_CLEAR: begin
            cmd.clear_cursor = 1'b1;
            cmd.cnt_clr      = 1'b1;
            state_next       = ST_CLEAR;
          end
          default: begin
            cmd.read_en = 1'b1;
            state_next  = ST_DONE;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.copy_en = 1'b1;
        cmd.cnt_inc = !status.copy_end;
        if (status.copy_end) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        cmd.fill_en = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.fill_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_busy;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/tmcw_datapath.sv]
// ----------------------------------------------------------------------------
// tmcw_datapath
// screen memory, cursor registers, sweep counter and result registers
// ----------------------------------------------------------------------------
module tmcw_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmcw_pkg::cmd_t                       cmd,
  output tmcw_pkg::status_t                    status,
  input  logic [1:0]                           kind,
  input  logic [7:0]                           char_code,
  input  logic [7:0]                           attr,
  input  logic [tmcw_pkg::CELL_ADDR_W-1:0]     cell_addr,
  output logic [tmcw_pkg::POS_W-1:0]           cursor_pos,
  output logic [tmcw_pkg::ROW_W-1:0]           cursor_row,
  output logic [tmcw_pkg::COL_W-1:0]           cursor_col,
  output logic [tmcw_pkg::CELL_W-1:0]          read_data,
  output logic                                 scrolled
);

  localparam int AW = tmcw_pkg::ADDR_W;
  localparam int SW = tmcw_pkg::COL_SUM_W;

  logic [tmcw_pkg::CELL_W-1:0] mem [tmcw_pkg::CELLS];

  logic [1:0]                          kind_q;
  logic [7:0]                          ch_q;
  logic [7:0]                          attr_q;
  logic [tmcw_pkg::CELL_ADDR_W-1:0]    addr_q;
  logic [tmcw_pkg::ROW_W-1:0]          row;
  logic [tmcw_pkg::ROW_W-1:0]          row_next;
  logic [tmcw_pkg::COL_W-1:0]          col;
  logic [tmcw_pkg::COL_W-1:0]          col_next;
  logic [AW-1:0]                       cnt;
  logic                                cp_valid;
  logic [AW-1:0]                       cp_addr;
  logic [tmcw_pkg::CELL_W-1:0]         rd_q;
  logic                                scr_flag;
  logic                                read_ok;

  logic                                adv;
  logic                                step_wr;
  logic [tmcw_pkg::COL_W-1:0]          step_col;
  logic [SW-1:0]                       col_sum;
  logic [AW-1:0]                       step_addr;
  logic [tmcw_pkg::CELL_W-1:0]         step_data;
  logic [AW-1:0]                       cur_addr;
  logic [AW-1:0]                       pos_full;

  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic [tmcw_pkg::CELL_W-1:0]         wr_data;
  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;
  logic [7:0]                          fill_attr;

  assign cur_addr = AW'(row) * AW'(tmcw_pkg::COLS) + AW'(col);

  // cursor update for put and remove
  always_comb begin
    adv       = 1'b0;
    step_wr   = 1'b0;
    step_col  = col;
    col_next  = col;
    col_sum   = SW'(col) + SW'(1);
    step_data = {attr_q, ch_q};
    if (kind_q == tmcw_pkg::KIND_PUT) begin
      if (ch_q == tmcw_pkg::CH_NEWLINE) begin
        adv      = 1'b1;
        col_next = '0;
      end else begin
        if (ch_q == tmcw_pkg::CH_TAB) begin
          col_sum = SW'(col) + SW'(tmcw_pkg::TAB_STEP);
        end else begin
          step_wr = 1'b1;
        end
        if (col_sum >= SW'(tmcw_pkg::COLS)) begin
          adv      = 1'b1;
          col_next = '0;
        end else begin
          col_next = col_sum[tmcw_pkg::COL_W-1:0];
        end
      end
    end else if (col != '0) begin
      step_wr   = 1'b1;
      step_col  = col - 1'b1;
      col_next  = step_col;
      step_data = {attr_q, tmcw_pkg::CH_SPACE};
    end
  end

  assign step_addr = AW'(row) * AW'(tmcw_pkg::COLS) + AW'(step_col);

  always_comb begin
    row_next = row;
    if (adv && (row != tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1))) begin
      row_next = row + 1'b1;
    end
  end

  assign status.scroll_req = adv && (row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
  assign status.copy_end   = (cnt == AW'(tmcw_pkg::CELLS - tmcw_pkg::COLS));
  assign status.fill_end   = (cnt == AW'(tmcw_pkg::CELLS - 1));
  assign status.kind       = kind_q;

  assign fill_attr = cmd.init_fill ? tmcw_pkg::RESET_ATTR : attr_q;

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = step_addr;
    wr_data = step_data;
    if (cp_valid) begin
      wr_en   = 1'b1;
      wr_addr = cp_addr;
      wr_data = rd_q;
    end else if (cmd.fill_en) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = {fill_attr, tmcw_pkg::CH_SPACE};
    end else if (cmd.step && step_wr) begin
      wr_en = 1'b1;
    end
  end

  // single read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(addr_q);
    if (cmd.copy_en && !status.copy_end) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt + AW'(tmcw_pkg::COLS));
    end else if (cmd.read_en) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      cnt      <= '0;
      cp_valid <= 1'b0;
    end else begin
      cp_valid <= cmd.copy_en && !status.copy_end;
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.clear_cursor) begin
        row <= '0;
        col <= '0;
      end else if (cmd.step) begin
        row <= row_next;
        col <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= cnt;
    if (cmd.capture) begin
      kind_q   <= kind;
      ch_q     <= char_code;
      attr_q   <= attr;
      addr_q   <= cell_addr;
      scr_flag <= 1'b0;
      read_ok  <= 1'b0;
    end else begin
      if (cmd.step) begin
        scr_flag <= status.scroll_req;
      end
      if (cmd.read_en) begin
        read_ok <= (addr_q < tmcw_pkg::CELL_ADDR_W'(tmcw_pkg::CELLS));
      end
    end
  end

  assign pos_full = cur_addr;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_pos <= tmcw_pkg::POS_W'(pos_full);
      cursor_row <= row;
      cursor_col <= col;
      read_data  <= read_ok ? rd_q : '0;
      scrolled   <= scr_flag;
    end
  end

endmodule

[hw/rtl/text_mode_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// text-cell screen writer with cursor, scroll, clear and cell read-back
// ----------------------------------------------------------------------------
// One item is handled at a time. Put, remove and read go from acceptance to
// result through accept, execute and result load, and the next item is taken
// while a result still waits at the output register. A put that moves below
// the last row scrolls the screen: the screen memory, with one read and one
// write port, copies one cell a cycle and then blanks the bottom row. A clear
// fills every cell. After reset the memory is filled with blanks, one cell a
// cycle, while no item is accepted.
`include "assert_macros.svh"

module text_mode_console_writer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic [7:0]                         char_code,
  input  logic [7:0]                         attr,
  input  logic [tmcw_pkg::CELL_ADDR_W-1:0]   cell_addr,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tmcw_pkg::POS_W-1:0]         cursor_pos,
  output logic [tmcw_pkg::ROW_W-1:0]         cursor_row,
  output logic [tmcw_pkg::COL_W-1:0]         cursor_col,
  output logic [tmcw_pkg::CELL_W-1:0]        read_data,
  output logic                               scrolled
);

  tmcw_pkg::cmd_t    cmd;
  tmcw_pkg::status_t status;

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tmcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .char_code  (char_code),
    .attr       (attr),
    .cell_addr  (cell_addr),
    .cursor_pos (cursor_pos),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .read_data  (read_data),
    .scrolled   (scrolled)
  );

  `ASSERT_IMP(a_accept_captures, in_valid && !in_stall, cmd.capture)
  `ASSERT_NEXT(a_exec_after_accept, in_valid && !in_stall, !cmd.fill_en && !cmd.copy_en)
  `ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !(out_valid && out_stall))
  `ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_valid)

endmodule

[tb/tb_text_mode_console_writer_core.sv]
// ----------------------------------------------------------------------------
// tb_text_mode_console_writer_core
// self-checking bench for the text-cell console writer: a scoreboard keeps its
// own screen, cursor and a queue of expected cursor reports; directed items hit
// the field extremes, then random text with newlines, tabs, removes, reads and
// the odd clear runs under random back-pressure on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_mode_console_writer_core;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int QUIET_ITEMS    = 150;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]                       kind;
    logic [7:0]                       char_code;
    logic [7:0]                       attr;
    logic [tmcw_pkg::CELL_ADDR_W-1:0] cell_addr;
  } console_item_t;

  typedef struct {
    logic [tmcw_pkg::POS_W-1:0]  cursor_pos;
    logic [tmcw_pkg::ROW_W-1:0]  cursor_row;
    logic [tmcw_pkg::COL_W-1:0]  cursor_col;
    logic [tmcw_pkg::CELL_W-1:0] read_data;
    logic                        scrolled;
  } cursor_report_t;

  class console_scoreboard;
    logic [tmcw_pkg::CELL_W-1:0] screen [tmcw_pkg::CELLS];
    int unsigned                 row;
    int unsigned                 col;
    cursor_report_t              pending[$];
    int                          errors;

    function new();
      blank_screen(tmcw_pkg::RESET_ATTR);
      row    = 0;
      col    = 0;
      errors = 0;
    endfunction

    function void blank_screen(logic [7:0] at);
      for (int i = 0; i < tmcw_pkg::CELLS; i++) screen[i] = {at, tmcw_pkg::CH_SPACE};
    endfunction

    function bit advance_row(logic [7:0] at);
      if (row + 1 < tmcw_pkg::ROWS) begin
        row++;
        return 1'b0;
      end
      for (int i = 0; i < tmcw_pkg::CELLS - tmcw_pkg::COLS; i++)
        screen[i] = screen[i + tmcw_pkg::COLS];
      for (int i = tmcw_pkg::CELLS - tmcw_pkg::COLS; i < tmcw_pkg::CELLS; i++)
        screen[i] = {at, tmcw_pkg::CH_SPACE};
      row = tmcw_pkg::ROWS - 1;
      return 1'b1;
    endfunction

    function void note_input(console_item_t it);
      cursor_report_t r;
      r.read_data = '0;
      r.scrolled  = 1'b0;
      case (it.kind)
        tmcw_pkg::KIND_PUT: begin
          if (it.char_code == tmcw_pkg::CH_NEWLINE) begin
            col        = 0;
            r.scrolled = advance_row(it.attr);
          end else if (it.char_code == tmcw_pkg::CH_TAB) begin
            col += tmcw_pkg::TAB_STEP;
            if (col >= tmcw_pkg::COLS) begin
              col        = 0;
              r.scrolled = advance_row(it.attr);
            end
          end else begin
            screen[row * tmcw_pkg::COLS + col] = {it.attr, it.char_code};
            col++;
            if (col >= tmcw_pkg::COLS) begin
              col        = 0;
              r.scrolled = advance_row(it.attr);
            end
          end
        end
        tmcw_pkg::KIND_REMOVE: begin
          if (col > 0) begin
            col--;
            screen[row * tmcw_pkg::COLS + col] = {it.attr, tmcw_pkg::CH_SPACE};
          end
        end
        tmcw_pkg::KIND_CLEAR: begin
          blank_screen(it.attr);
          row = 0;
          col = 0;
        end
        tmcw_pkg::KIND_READ: begin
          if (it.cell_addr < tmcw_pkg::CELLS) r.read_data = screen[it.cell_addr];
        end
        default: ;
      endcase
      r.cursor_pos = tmcw_pkg::POS_W'(row * tmcw_pkg::COLS + col);
      r.cursor_row = tmcw_pkg::ROW_W'(row);
      r.cursor_col = tmcw_pkg::COL_W'(col);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: report with no item outstanding, expected none actual pos %0d",
                 $time, got.cursor_pos);
        return;
      end
      want = pending.pop_front();
      compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("scrolled", want.scrolled, got.scrolled);
    endfunction
  endclass

  logic                             clk;
  logic                             rst        = 1'b1;
  logic                             in_valid   = 1'b0;
  logic                             in_stall;
  logic [1:0]                       kind       = tmcw_pkg::KIND_READ;
  logic [7:0]                       char_code  = '0;
  logic [7:0]                       attr       = '0;
  logic [tmcw_pkg::CELL_ADDR_W-1:0] cell_addr  = '0;
  logic                             out_valid;
  logic                             out_stall  = 1'b0;
  logic [tmcw_pkg::POS_W-1:0]       cursor_pos;
  logic [tmcw_pkg::ROW_W-1:0]       cursor_row;
  logic [tmcw_pkg::COL_W-1:0]       cursor_col;
  logic [tmcw_pkg::CELL_W-1:0]      read_data;
  logic                             scrolled;

  console_scoreboard sb = new();
  int                idle_pct      = 20;
  bit                long_hold_req = 1'b0;

  text_mode_console_writer_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .char_code  (char_code),
    .attr       (attr),
    .cell_addr  (cell_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .read_data  (read_data),
    .scrolled   (scrolled)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic console_item_t make_item(logic [1:0] k, logic [7:0] c, logic [7:0] a,
                                              logic [tmcw_pkg::CELL_ADDR_W-1:0] ad);
    console_item_t it;
    it.kind      = k;
    it.char_code = c;
    it.attr      = a;
    it.cell_addr = ad;
    return it;
  endfunction

  function automatic console_item_t random_item(int unsigned cur_row);
    console_item_t it;
    int unsigned   pick;
    int unsigned   sub;
    it.char_code = 8'($urandom_range(0, 255));
    it.attr      = 8'($urandom_range(0, 255));
    it.cell_addr = tmcw_pkg::CELL_ADDR_W'($urandom_range(0, 2047));
    pick         = $urandom_range(0, 999);
    if (pick < 8) begin
      it.kind = tmcw_pkg::KIND_CLEAR;
    end else if (pick < 110) begin
      it.kind = tmcw_pkg::KIND_REMOVE;
    end else if (pick < 290) begin
      it.kind = tmcw_pkg::KIND_READ;
      sub     = $urandom_range(0, 9);
      if (sub == 0)
        it.cell_addr = tmcw_pkg::CELL_ADDR_W'($urandom_range(tmcw_pkg::CELLS, 2047));
      else if (sub < 6)
        it.cell_addr = tmcw_pkg::CELL_ADDR_W'(cur_row * tmcw_pkg::COLS +
                                              $urandom_range(0, tmcw_pkg::COLS - 1));
      else
        it.cell_addr = tmcw_pkg::CELL_ADDR_W'($urandom_range(0, tmcw_pkg::CELLS - 1));
    end else begin
      it.kind = tmcw_pkg::KIND_PUT;
      sub     = $urandom_range(0, 99);
      if (sub < 6)
        it.char_code = tmcw_pkg::CH_NEWLINE;
      else if (sub < 14)
        it.char_code = tmcw_pkg::CH_TAB;
    end
    return it;
  endfunction

  task automatic offer(console_item_t it);
    in_valid  <= 1'b1;
    kind      <= it.kind;
    char_code <= it.char_code;
    attr      <= it.attr;
    cell_addr <= it.cell_addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic hold_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin : stimulus
    console_item_t directed[$];
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'hff, 8'hff, 11'd1999));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2000));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2047));
    directed.push_back(make_item(tmcw_pkg::KIND_REMOVE, 8'h00, 8'haa, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, 8'h00, 8'h00, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, 8'hff, 8'hff, 11'd2047));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, 8'h41, 8'h5a, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd1));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2));
    directed.push_back(make_item(tmcw_pkg::KIND_REMOVE, 8'h00, 8'h33, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, tmcw_pkg::CH_TAB, 8'h12, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, tmcw_pkg::CH_NEWLINE, 8'h34, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_PUT, 8'h7e, 8'hc3, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd80));
    directed.push_back(make_item(tmcw_pkg::KIND_CLEAR, 8'h00, 8'h00, 11'd0));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd1999));
    directed.push_back(make_item(tmcw_pkg::KIND_CLEAR, 8'hff, 8'hff, 11'd2047));
    directed.push_back(make_item(tmcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd555));
    directed.push_back(make_item(tmcw_pkg::KIND_REMOVE, 8'h00, 8'h00, 11'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer(directed[i]);
      if ($urandom_range(0, 99) < idle_pct) hold_sender($urandom_range(1, 7));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_ITEMS)
        idle_pct = 0;
      else if (n % 50 == 0)
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      if (n == 300) long_hold_req = 1'b1;
      offer(random_item(sb.row));
      if (n == 600) begin
        // let the block drain completely before carrying on
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        hold_sender($urandom_range(1, 7));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    cursor_report_t got;
    int             stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.cursor_pos = cursor_pos;
        got.cursor_row = cursor_row;
        got.cursor_col = cursor_col;
        got.read_data  = read_data;
        got.scrolled   = scrolled;
        sb.check_report(got);
      end
      if (stall_left > 0)
        stall_left--;
      else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if ($urandom_range(0, 99) < idle_pct)
        stall_left = $urandom_range(1, 7);
      out_stall <= (stall_left > 0);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
